### hw/rtl/pwdr_pkg.sv
// shared types, constants and helpers for the period window duty regulator
// no dependencies; used by pwdr_core and period_window_duty_regulator_top
package pwdr_pkg;

    localparam logic [15:0] DUTY_STEP_RESET    = 16'd500;
    localparam logic [15:0] DUTY_CEILING_RESET = 16'hFDFF;
    localparam logic [15:0] DUTY_RESET         = 16'hDFFF;
    localparam logic [7:0]  UPPER_RESET        = 8'd55;
    localparam logic [7:0]  LOWER_RESET        = 8'd52;

    // configuration register indexes
    localparam logic CFG_DUTY_STEP    = 1'b0;
    localparam logic CFG_DUTY_CEILING = 1'b1;

    // action codes
    localparam logic ACT_SENSOR = 1'b0;
    localparam logic ACT_KEY    = 1'b1;

    // key codes
    localparam logic [1:0] KEY_RAISE = 2'd1;
    localparam logic [1:0] KEY_LOWER = 2'd2;

    // result kinds
    localparam logic KIND_PERIOD = 1'b0;
    localparam logic KIND_LOWER  = 1'b1;

    // period = elapsed / 500 = (elapsed >> 2) / 125, done as (x * 16778) >> 21
    localparam logic [14:0] PERIOD_RECIP = 15'd16778;
    localparam int          PERIOD_SHIFT = 21;

    typedef struct packed {
        logic        action;
        logic [15:0] timer_count;
        logic [1:0]  key_bits;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] duty;
        logic        status_led;
        logic [3:0]  digit_hundreds;
        logic [3:0]  digit_tens;
        logic [3:0]  digit_units;
    } out_t;

    typedef struct packed {
        logic [15:0] duty_value;
        logic [7:0]  upper_bound;
        logic [7:0]  lower_bound;
        logic        awaiting_stop;
        logic [15:0] start_count;
        logic        led_state;
    } state_t;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // decimal split of an 8-bit value through reciprocal multiplies
    function automatic digits_t split_digits(input logic [7:0] v);
        logic [13:0] h_prod;
        logic [15:0] t_prod;
        logic [1:0]  h;
        logic [4:0]  q10;
        logic [4:0]  tens_w;
        logic [7:0]  units_w;
        digits_t     d;
        h_prod  = 14'(v) * 14'd41;
        t_prod  = 16'(v) * 16'd205;
        h       = h_prod[13:12];
        q10     = t_prod[15:11];
        tens_w  = q10 - 5'(h) * 5'd10;
        units_w = v - 8'(q10) * 8'd10;
        d.hundreds = 4'(h);
        d.tens     = tens_w[3:0];
        d.units    = units_w[3:0];
        return d;
    endfunction

endpackage

### hw/rtl/pwdr_core.sv
// next-state and result logic for one transaction of the regulator
// depends on pwdr_pkg
module pwdr_core (
    input  pwdr_pkg::in_t    item,
    input  pwdr_pkg::state_t cur,
    input  logic [15:0]      duty_step,
    input  logic [15:0]      duty_ceiling,
    output pwdr_pkg::state_t nxt,
    output pwdr_pkg::out_t   result,
    output logic             has_result
);

    logic [15:0]       elapsed;
    logic [28:0]       period_prod;
    logic [7:0]        period;
    logic [16:0]       duty_sum;
    logic [7:0]        shown;
    pwdr_pkg::digits_t digits;

    always_comb
    begin
        elapsed     = item.timer_count - cur.start_count;
        period_prod = 29'(elapsed[15:2]) * 29'(pwdr_pkg::PERIOD_RECIP);
        period      = period_prod[pwdr_pkg::PERIOD_SHIFT +: 8];
        duty_sum    = 17'(cur.duty_value) + 17'(duty_step);
    end

    always_comb
    begin
        nxt        = cur;
        has_result = 1'b0;
        shown      = period;
        if (item.action == pwdr_pkg::ACT_KEY)
        begin
            unique case (item.key_bits)
                pwdr_pkg::KEY_RAISE:
                begin
                    nxt.upper_bound = cur.upper_bound + 8'd1;
                    nxt.lower_bound = cur.lower_bound + 8'd1;
                end
                pwdr_pkg::KEY_LOWER:
                begin
                    nxt.upper_bound = cur.upper_bound - 8'd1;
                    nxt.lower_bound = cur.lower_bound - 8'd1;
                end
                default:
                begin
                end
            endcase
            has_result = 1'b1;
            shown      = nxt.lower_bound;
        end
        else if (!cur.awaiting_stop)
        begin
            nxt.start_count   = item.timer_count;
            nxt.awaiting_stop = 1'b1;
        end
        else
        begin
            priority if (period < cur.upper_bound && period > cur.lower_bound)
            begin
                nxt.led_state = 1'b1;
            end
            else if (period < cur.upper_bound)
            begin
                // decrement saturates at zero
                nxt.duty_value = (cur.duty_value > duty_step)
                                 ? cur.duty_value - duty_step : 16'd0;
                nxt.led_state  = 1'b0;
            end
            else if (cur.duty_value < duty_ceiling)
            begin
                nxt.duty_value = duty_sum[16] ? 16'hFFFF : duty_sum[15:0];
                nxt.led_state  = 1'b0;
            end
            else
            begin
            end
            nxt.awaiting_stop = 1'b0;
            has_result        = 1'b1;
        end
    end

    always_comb
    begin
        digits                = pwdr_pkg::split_digits(shown);
        result.result_kind    = (item.action == pwdr_pkg::ACT_KEY)
                                ? pwdr_pkg::KIND_LOWER : pwdr_pkg::KIND_PERIOD;
        result.duty           = nxt.duty_value;
        result.status_led     = nxt.led_state;
        result.digit_hundreds = digits.hundreds;
        result.digit_tens     = digits.tens;
        result.digit_units    = digits.units;
    end

endmodule

### hw/rtl/period_window_duty_regulator_top.sv
// top level of the period window duty regulator: input register, state, result register
// depends on pwdr_pkg and pwdr_core
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall   pwdr_pkg::in_t
// out      out  out_valid / out_stall pwdr_pkg::out_t
// cfg      in   cfg_we                cfg_index, cfg_data
//
// one transaction per cycle while out does not stall; an accepted input is held in
// the input register, then its result loads the result register and out_valid rises
// a start edge gives no result and leaves the input register even while out stalls
// rst_n restores the bounds, duty, step and ceiling and empties both registers
// a stalled result holds; the input register keeps draining into it when it frees
module period_window_duty_regulator_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pwdr_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output pwdr_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);

    pwdr_pkg::in_t    item_reg;
    logic             item_valid_reg;
    pwdr_pkg::state_t state_reg;
    pwdr_pkg::state_t state_next;
    pwdr_pkg::out_t   out_reg;
    pwdr_pkg::out_t   out_next;
    logic             out_valid_reg;
    logic [15:0]      step_reg;
    logic [15:0]      ceiling_reg;
    logic             has_result;
    logic             out_free;
    logic             advance;
    logic             in_take;

    pwdr_core u_core (
        .item         (item_reg),
        .cur          (state_reg),
        .duty_step    (step_reg),
        .duty_ceiling (ceiling_reg),
        .nxt          (state_next),
        .result       (out_next),
        .has_result   (has_result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = item_valid_reg && (!has_result || out_free);
    assign in_stall  = item_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg          <= 1'b0;
            out_valid_reg           <= 1'b0;
            step_reg                <= pwdr_pkg::DUTY_STEP_RESET;
            ceiling_reg             <= pwdr_pkg::DUTY_CEILING_RESET;
            state_reg.duty_value    <= pwdr_pkg::DUTY_RESET;
            state_reg.upper_bound   <= pwdr_pkg::UPPER_RESET;
            state_reg.lower_bound   <= pwdr_pkg::LOWER_RESET;
            state_reg.awaiting_stop <= 1'b0;
            state_reg.start_count   <= 16'd0;
            state_reg.led_state     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pwdr_pkg::CFG_DUTY_STEP:    step_reg    <= cfg_data;
                    pwdr_pkg::CFG_DUTY_CEILING: ceiling_reg <= cfg_data;
                    default:                    step_reg    <= step_reg;
                endcase
            end
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        if (advance && has_result)
        begin
            out_reg <= out_next;
        end
    end

endmodule
